// ===== rtl/rtld_pkg.sv =====
package rtld_pkg;

  localparam int FRAC_BITS = 24;
  localparam int DW = 32;

  typedef logic signed [DW-1:0] word_t;

  typedef enum logic [1:0] {
    REG_K1 = 2'd0,
    REG_K2 = 2'd1,
    REG_P1 = 2'd2,
    REG_P2 = 2'd3
  } reg_idx_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic word_t sat(input logic signed [71:0] v);
    logic signed [71:0] hi;
    logic signed [71:0] lo;
    hi = 72'sd2147483647;
    lo = -72'sd2147483648;
    if (v > hi) begin
      sat = 32'sh7fffffff;
    end else if (v < lo) begin
      sat = 32'sh80000000;
    end else begin
      sat = v[31:0];
    end
  endfunction

endpackage

// ===== rtl/rtld_fmul.sv =====
// Registered fixed-point product: round half up, floor shift, saturate.
module rtld_fmul #(
  parameter int FRAC_BITS = rtld_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  rtld_pkg::word_t      a,
  input  rtld_pkg::word_t      b,
  output rtld_pkg::word_t      p
);
  logic signed [63:0] prod;
  logic signed [71:0] rnd;

  always_comb begin
    prod = a * b;
    rnd  = (72'(prod) + (72'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= rtld_pkg::sat(rnd);
    end
  end
endmodule

// ===== rtl/radtan_lens_distortion.sv =====
// Channel  | valid       | stall       | payload
// ---------+-------------+-------------+-------------------------------------
// in       | in_valid    | in_stall    | x_in, y_in
// out      | out_valid   | out_stall   | x_out ... dy_dp1 (twelve fields)
// cfg      | cfg_we      | -           | cfg_index, cfg_data
//
// One point per cycle while no stalled result holds the pipeline; six
// register stages, one per step of the dependent chain x^2 -> r2 ->
// r^4 -> k2*r^4 -> R -> x*R, lie between a point and its result.
// Reset clears all stage valid bits and the coefficients.
// A stall on a valid result holds every stage and stalls the input in the
// same cycle; a stall with no result waiting holds nothing.
module radtan_lens_distortion #(
  parameter int FRAC_BITS = rtld_pkg::FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  rtld_pkg::word_t        cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  rtld_pkg::word_t        x_in,
  input  rtld_pkg::word_t        y_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output rtld_pkg::word_t        x_out,
  output rtld_pkg::word_t        y_out,
  output rtld_pkg::word_t        jac_xx,
  output rtld_pkg::word_t        jac_xy,
  output rtld_pkg::word_t        jac_yy,
  output rtld_pkg::word_t        dx_dk1,
  output rtld_pkg::word_t        dx_dk2,
  output rtld_pkg::word_t        two_xy,
  output rtld_pkg::word_t        dx_dp2,
  output rtld_pkg::word_t        dy_dk1,
  output rtld_pkg::word_t        dy_dk2,
  output rtld_pkg::word_t        dy_dp1
);
  localparam int NST = 6;
  localparam logic signed [71:0] ONE = 72'sd1 <<< FRAC_BITS;

  rtld_pkg::word_t k1, k2, p1, p2;
  logic [NST-1:0] vld;
  logic adv;

  // whole pipeline advances unless the output holds a result being stalled
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      k1 <= '0; k2 <= '0; p1 <= '0; p2 <= '0;
    end else if (cfg_we) begin
      unique case (rtld_pkg::reg_idx_t'(cfg_index))
        rtld_pkg::REG_K1: k1 <= cfg_data;
        rtld_pkg::REG_K2: k2 <= cfg_data;
        rtld_pkg::REG_P1: p1 <= cfg_data;
        rtld_pkg::REG_P2: p2 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // stage 1: x2, y2, xy, k1x, k1y, p1x, p1y, p2x, p2y
  rtld_pkg::word_t x1, y1, x2, y2, xy, k1x, k1y, p1x, p1y, p2x, p2y;
  always_ff @(posedge clk) if (adv) begin x1 <= x_in; y1 <= y_in; end
  rtld_fmul #(FRAC_BITS) u_x2 (clk, adv, x_in, x_in, x2);
  rtld_fmul #(FRAC_BITS) u_y2 (clk, adv, y_in, y_in, y2);
  rtld_fmul #(FRAC_BITS) u_xy (clk, adv, x_in, y_in, xy);
  rtld_fmul #(FRAC_BITS) u_k1x (clk, adv, k1, x_in, k1x);
  rtld_fmul #(FRAC_BITS) u_k1y (clk, adv, k1, y_in, k1y);
  rtld_fmul #(FRAC_BITS) u_p1x (clk, adv, p1, x_in, p1x);
  rtld_fmul #(FRAC_BITS) u_p1y (clk, adv, p1, y_in, p1y);
  rtld_fmul #(FRAC_BITS) u_p2x (clk, adv, p2, x_in, p2x);
  rtld_fmul #(FRAC_BITS) u_p2y (clk, adv, p2, y_in, p2y);

  // stage 2: sums of squares
  rtld_pkg::word_t x_2, y_2, r2, sx, sy, xy_2, x2_2, y2_2, k1x_2, k1y_2;
  rtld_pkg::word_t p1x_2, p1y_2, p2x_2, p2y_2;
  always_ff @(posedge clk) if (adv) begin
    x_2 <= x1; y_2 <= y1; xy_2 <= xy; x2_2 <= x2; y2_2 <= y2;
    k1x_2 <= k1x; k1y_2 <= k1y;
    p1x_2 <= p1x; p1y_2 <= p1y; p2x_2 <= p2x; p2y_2 <= p2y;
    r2 <= rtld_pkg::sat(72'(x2) + 72'(y2));
  end
  // r2 + 2*x2 uses the saturated r2, so form it from stage 2 registers
  always_comb begin
    sx = rtld_pkg::sat(72'(r2) + 72'(x2_2) * 2);
    sy = rtld_pkg::sat(72'(r2) + 72'(y2_2) * 2);
  end

  // stage 3: r4, xr2, yr2, k1r2, p2sx, p1sy, p1xy, p2xy
  rtld_pkg::word_t r4, xr2, yr2, k1r2, p2sx, p1sy, p1xy, p2xy;
  rtld_pkg::word_t x_3, y_3, xy_3, x2_3, y2_3, k1x_3, k1y_3;
  rtld_pkg::word_t p1x_3, p1y_3, p2x_3, p2y_3;
  always_ff @(posedge clk) if (adv) begin
    x_3 <= x_2; y_3 <= y_2; xy_3 <= xy_2; x2_3 <= x2_2; y2_3 <= y2_2;
    k1x_3 <= k1x_2; k1y_3 <= k1y_2;
    p1x_3 <= p1x_2; p1y_3 <= p1y_2; p2x_3 <= p2x_2; p2y_3 <= p2y_2;
  end
  rtld_fmul #(FRAC_BITS) u_r4 (clk, adv, r2, r2, r4);
  rtld_fmul #(FRAC_BITS) u_xr2 (clk, adv, x_2, r2, xr2);
  rtld_fmul #(FRAC_BITS) u_yr2 (clk, adv, y_2, r2, yr2);
  rtld_fmul #(FRAC_BITS) u_k1r2 (clk, adv, k1, r2, k1r2);
  rtld_fmul #(FRAC_BITS) u_p2sx (clk, adv, p2, sx, p2sx);
  rtld_fmul #(FRAC_BITS) u_p1sy (clk, adv, p1, sy, p1sy);
  rtld_fmul #(FRAC_BITS) u_p1xy (clk, adv, p1, xy_2, p1xy);
  rtld_fmul #(FRAC_BITS) u_p2xy (clk, adv, p2, xy_2, p2xy);

  // stage 4: k2*r4, k2*xr2, k2*yr2, x*r4, y*r4
  rtld_pkg::word_t k2r4, k2xr2, k2yr2, xr4, yr4;
  rtld_pkg::word_t x_4, y_4, xy_4, x2_4, y2_4, k1x_4, k1y_4, xr2_4, yr2_4;
  rtld_pkg::word_t k1r2_4, p2sx_4, p1sy_4, p1xy_4, p2xy_4;
  rtld_pkg::word_t p1x_4, p1y_4, p2x_4, p2y_4;
  always_ff @(posedge clk) if (adv) begin
    x_4 <= x_3; y_4 <= y_3; xy_4 <= xy_3; x2_4 <= x2_3; y2_4 <= y2_3;
    k1x_4 <= k1x_3; k1y_4 <= k1y_3; xr2_4 <= xr2; yr2_4 <= yr2;
    k1r2_4 <= k1r2; p2sx_4 <= p2sx; p1sy_4 <= p1sy;
    p1xy_4 <= p1xy; p2xy_4 <= p2xy;
    p1x_4 <= p1x_3; p1y_4 <= p1y_3; p2x_4 <= p2x_3; p2y_4 <= p2y_3;
  end
  rtld_fmul #(FRAC_BITS) u_k2r4 (clk, adv, k2, r4, k2r4);
  rtld_fmul #(FRAC_BITS) u_k2xr2 (clk, adv, k2, xr2, k2xr2);
  rtld_fmul #(FRAC_BITS) u_k2yr2 (clk, adv, k2, yr2, k2yr2);
  rtld_fmul #(FRAC_BITS) u_xr4 (clk, adv, x_3, r4, xr4);
  rtld_fmul #(FRAC_BITS) u_yr4 (clk, adv, y_3, r4, yr4);

  // stage 5: rad, gx, gy registered, then products with rad and gradients
  rtld_pkg::word_t rad, gx, gy;
  rtld_pkg::word_t x_5, y_5, xy_5, x2_5, y2_5, xr2_5, yr2_5, xr4_5, yr4_5;
  rtld_pkg::word_t p2sx_5, p1sy_5, p1xy_5, p2xy_5, p1x_5, p1y_5, p2x_5, p2y_5;
  always_ff @(posedge clk) if (adv) begin
    rad <= rtld_pkg::sat(ONE + 72'(k1r2_4) + 72'(k2r4));
    gx  <= rtld_pkg::sat(72'(k1x_4) * 2 + 72'(k2xr2) * 4);
    gy  <= rtld_pkg::sat(72'(k1y_4) * 2 + 72'(k2yr2) * 4);
    x_5 <= x_4; y_5 <= y_4; xy_5 <= xy_4; x2_5 <= x2_4; y2_5 <= y2_4;
    xr2_5 <= xr2_4; yr2_5 <= yr2_4; xr4_5 <= xr4; yr4_5 <= yr4;
    p2sx_5 <= p2sx_4; p1sy_5 <= p1sy_4; p1xy_5 <= p1xy_4; p2xy_5 <= p2xy_4;
    p1x_5 <= p1x_4; p1y_5 <= p1y_4; p2x_5 <= p2x_4; p2y_5 <= p2y_4;
  end

  // stage 6: x*rad, y*rad, x*gx, y*gx, y*gy and final sums
  rtld_pkg::word_t xrad, yrad, xgx, ygx, ygy;
  rtld_pkg::word_t rad_6, xy_6, x2_6, y2_6, p2sx_6, p1sy_6, p1xy_6, p2xy_6;
  rtld_pkg::word_t p1x_6, p1y_6, p2x_6, p2y_6;
  rtld_fmul #(FRAC_BITS) u_xrad (clk, adv, x_5, rad, xrad);
  rtld_fmul #(FRAC_BITS) u_yrad (clk, adv, y_5, rad, yrad);
  rtld_fmul #(FRAC_BITS) u_xgx (clk, adv, x_5, gx, xgx);
  rtld_fmul #(FRAC_BITS) u_ygx (clk, adv, y_5, gx, ygx);
  rtld_fmul #(FRAC_BITS) u_ygy (clk, adv, y_5, gy, ygy);
  always_ff @(posedge clk) if (adv) begin
    rad_6 <= rad; xy_6 <= xy_5; x2_6 <= x2_5; y2_6 <= y2_5;
    p2sx_6 <= p2sx_5; p1sy_6 <= p1sy_5; p1xy_6 <= p1xy_5; p2xy_6 <= p2xy_5;
    p1x_6 <= p1x_5; p1y_6 <= p1y_5; p2x_6 <= p2x_5; p2y_6 <= p2y_5;
    dx_dk1 <= xr2_5; dy_dk1 <= yr2_5; dx_dk2 <= xr4_5; dy_dk2 <= yr4_5;
  end

  always_comb begin
    x_out  = rtld_pkg::sat(72'(xrad) + 72'(p1xy_6) * 2 + 72'(p2sx_6));
    y_out  = rtld_pkg::sat(72'(yrad) + 72'(p1sy_6) + 72'(p2xy_6) * 2);
    jac_xx = rtld_pkg::sat(72'(rad_6) + 72'(p1y_6) * 2 + 72'(p2x_6) * 6 + 72'(xgx));
    jac_xy = rtld_pkg::sat(72'(p1x_6) * 2 + 72'(p2y_6) * 2 + 72'(ygx));
    jac_yy = rtld_pkg::sat(72'(rad_6) + 72'(p1y_6) * 6 + 72'(p2x_6) * 2 + 72'(ygy));
    two_xy = rtld_pkg::sat(72'(xy_6) * 2);
    dx_dp2 = rtld_pkg::sat(72'(x2_6) * 3 + 72'(y2_6));
    dy_dp1 = rtld_pkg::sat(72'(x2_6) + 72'(y2_6) * 3);
  end

  // a stalled result holds its valid
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result lost under stall");
  // input is refused only while a result waits
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("stall without pending result");
  // an accepted point shows up after the pipeline depth when nothing stalls
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall ##1 !in_stall
    ##1 !in_stall |=> out_valid) else $error("pipeline dropped a point");
endmodule
